// File: hdl/ec_scalar_multiply_small_prime_macros.svh
// Assertion macros shared by the scalar multiplier RTL.
`ifndef EC_SCALAR_MULTIPLY_SMALL_PRIME_MACROS_SVH
`define EC_SCALAR_MULTIPLY_SMALL_PRIME_MACROS_SVH
`ifndef SYNTHESIS
`define ECSM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ecsm assertion failed");
`define ECSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ecsm assertion failed");
`else
`define ECSM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ECSM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/ecsm_pkg.sv
// Types, microcode and modular helpers for the scalar multiplier.
package ecsm_pkg;
	localparam int CW = 8;
	localparam int SW = 8;
	localparam int KCNT_W = (SW > 1) ? $clog2(SW) : 1;
	localparam int MCNT_W = $clog2(CW);
	localparam int PC_W = 6;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	typedef logic [CW-1:0] coord_t;

	typedef enum logic [2:0] {
		OP_END, OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_MOD, OP_INV
	} op_t;

	typedef enum logic [2:0] {
		R_X, R_Y, R_BX, R_BY, R_A, R_S, R_T0, R_T1
	} reg_t;

	typedef enum logic {
		REG_PRIME = 1'b0,
		REG_CURVE_A = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		op_t  op;
		reg_t dst;
		reg_t s1;
		reg_t s2;
	} uop_t;

	typedef struct packed {
		logic load;
		logic go;
		uop_t uop;
		logic set_inf;
		logic clr_inf;
		logic shift_k;
		logic capture;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic inf;
		logic y_zero;
		logic x_eq;
		logic y_eq;
		logic kbit;
		logic m_small;
	} stat_t;

	localparam logic [PC_W-1:0] PC_RED = PC_W'(0);
	localparam logic [PC_W-1:0] PC_DBL = PC_W'(4);
	localparam logic [PC_W-1:0] PC_ADD = PC_W'(19);
	localparam logic [PC_W-1:0] PC_LDB = PC_W'(31);

	function automatic uop_t uc_fetch(input logic [PC_W-1:0] pc);
		uop_t u;
		u = '{OP_END, R_X, R_X, R_X};
		case (pc)
			// operand reduction
			6'd0:  u = '{OP_MOD, R_BX, R_BX, R_BX};
			6'd1:  u = '{OP_MOD, R_BY, R_BY, R_BY};
			6'd2:  u = '{OP_MOD, R_A, R_A, R_A};
			// doubling: slope = (3x^2 + a) / 2y
			6'd4:  u = '{OP_MUL, R_T0, R_X, R_X};
			6'd5:  u = '{OP_ADD, R_T1, R_T0, R_T0};
			6'd6:  u = '{OP_ADD, R_T1, R_T1, R_T0};
			6'd7:  u = '{OP_ADD, R_T1, R_T1, R_A};
			6'd8:  u = '{OP_ADD, R_T0, R_Y, R_Y};
			6'd9:  u = '{OP_INV, R_T0, R_T0, R_T0};
			6'd10: u = '{OP_MUL, R_S, R_T1, R_T0};
			6'd11: u = '{OP_MUL, R_T0, R_S, R_S};
			6'd12: u = '{OP_SUB, R_T0, R_T0, R_X};
			6'd13: u = '{OP_SUB, R_T0, R_T0, R_X};
			6'd14: u = '{OP_SUB, R_T1, R_X, R_T0};
			6'd15: u = '{OP_MUL, R_T1, R_S, R_T1};
			6'd16: u = '{OP_SUB, R_Y, R_T1, R_Y};
			6'd17: u = '{OP_MOV, R_X, R_T0, R_T0};
			// addition of the base point
			6'd19: u = '{OP_SUB, R_T0, R_BY, R_Y};
			6'd20: u = '{OP_SUB, R_T1, R_BX, R_X};
			6'd21: u = '{OP_INV, R_T1, R_T1, R_T1};
			6'd22: u = '{OP_MUL, R_S, R_T0, R_T1};
			6'd23: u = '{OP_MUL, R_T0, R_S, R_S};
			6'd24: u = '{OP_SUB, R_T0, R_T0, R_X};
			6'd25: u = '{OP_SUB, R_T0, R_T0, R_BX};
			6'd26: u = '{OP_SUB, R_T1, R_X, R_T0};
			6'd27: u = '{OP_MUL, R_T1, R_S, R_T1};
			6'd28: u = '{OP_SUB, R_Y, R_T1, R_Y};
			6'd29: u = '{OP_MOV, R_X, R_T0, R_T0};
			// accumulator takes the base point
			6'd31: u = '{OP_MOV, R_X, R_BX, R_BX};
			6'd32: u = '{OP_MOV, R_Y, R_BY, R_BY};
			default: u = '{OP_END, R_X, R_X, R_X};
		endcase
		return u;
	endfunction

	function automatic coord_t add_m(input coord_t u, input coord_t v, input coord_t m);
		logic [CW:0] s;
		s = {1'b0, u} + {1'b0, v};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[CW-1:0];
	endfunction

	function automatic coord_t sub_m(input coord_t u, input coord_t v, input coord_t m);
		logic [CW:0] s;
		s = {1'b0, u} - {1'b0, v};
		if (u < v) begin
			s = s + {1'b0, m};
		end
		return s[CW-1:0];
	endfunction
endpackage

// File: hdl/ec_scalar_multiply_small_prime.sv
// Top level of the elliptic-curve scalar multiplier: configuration registers and wiring.
// Computes k*(x,y) on y^2 = x^3 + a*x + b over GF(p) by double-and-add from the top scalar
// bit, with affine formulas and the point at infinity handled. One item is in work at a
// time; a finished result waits in an output register while the next item is taken. The
// time per item is data dependent: every point operation runs as a microcode sequence of
// modular operations on one shared serial ALU (shift-add multiply, modular add/sub, an issue
// step per operation), and its modular inverse is a linear search over the candidates 1 to
// p-1, which dominates. Leading zero scalar bits skip the doubling while the accumulator is
// at infinity, and an item with a modulus below two skips the computation altogether.
`include "ec_scalar_multiply_small_prime_macros.svh"
module ec_scalar_multiply_small_prime import ecsm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [SW-1:0]     scalar_k,
	input  coord_t            point_x,
	input  coord_t            point_y,
	output logic              out_valid,
	input  logic              out_ready,
	output coord_t            result_x,
	output coord_t            result_y,
	output logic              result_is_infinity
);
	coord_t field_prime_q, curve_a_q;
	cfg_reg_t cfg_sel;
	cmd_t cmd;
	stat_t stat;

	assign cfg_sel = cfg_reg_t'(paddr[2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_prime_q <= coord_t'(23);
			curve_a_q <= coord_t'(1);
		end else if (psel && penable && pwrite) begin
			case (cfg_sel)
				REG_PRIME:   field_prime_q <= pwdata[CW-1:0];
				REG_CURVE_A: curve_a_q <= pwdata[CW-1:0];
				default:     field_prime_q <= field_prime_q;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			REG_PRIME:   prdata = DATA_W'(field_prime_q);
			REG_CURVE_A: prdata = DATA_W'(curve_a_q);
			default:     prdata = '0;
		endcase
	end

	ecsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ecsm_datapath u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.field_prime        (field_prime_q),
		.curve_a            (curve_a_q),
		.scalar_k           (scalar_k),
		.point_x            (point_x),
		.point_y            (point_y),
		.result_x           (result_x),
		.result_y           (result_y),
		.result_is_infinity (result_is_infinity)
	);
endmodule

// File: hdl/ecsm_datapath.sv
// Register file, serial modular ALU and result register of the scalar multiplier.
`include "ec_scalar_multiply_small_prime_macros.svh"
module ecsm_datapath import ecsm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	output stat_t        stat,
	input  coord_t       field_prime,
	input  coord_t       curve_a,
	input  logic [SW-1:0] scalar_k,
	input  coord_t       point_x,
	input  coord_t       point_y,
	output coord_t       result_x,
	output coord_t       result_y,
	output logic         result_is_infinity
);
	coord_t x_q, y_q, bx_q, by_q, a_q, s_q, t0_q, t1_q;
	logic inf_q;
	logic [SW-1:0] k_q;
	coord_t rd1, rd2;

	op_t op_q;
	reg_t dst_q;
	logic busy_q, done_q;
	coord_t u_q, v_q, r_q, t_q, p_q;
	logic [MCNT_W-1:0] cnt_q;

	logic wr_en;
	coord_t wr_data, mul_next, dbl;

	coord_t res_x_q, res_y_q;
	logic res_inf_q;

	function automatic coord_t rd_sel(input reg_t sel, input coord_t x, input coord_t y,
			input coord_t bx, input coord_t by, input coord_t a, input coord_t s,
			input coord_t t0, input coord_t t1);
		coord_t v;
		case (sel)
			R_X:  v = x;
			R_Y:  v = y;
			R_BX: v = bx;
			R_BY: v = by;
			R_A:  v = a;
			R_S:  v = s;
			R_T0: v = t0;
			R_T1: v = t1;
			default: v = '0;
		endcase
		return v;
	endfunction

	assign rd1 = rd_sel(cmd.uop.s1, x_q, y_q, bx_q, by_q, a_q, s_q, t0_q, t1_q);
	assign rd2 = rd_sel(cmd.uop.s2, x_q, y_q, bx_q, by_q, a_q, s_q, t0_q, t1_q);

	always_comb begin
		dbl = add_m(r_q, r_q, field_prime);
		mul_next = v_q[CW-1] ? add_m(dbl, u_q, field_prime) : dbl;
		wr_en = 1'b0;
		wr_data = '0;
		if (busy_q) begin
			case (op_q)
				OP_MOV: begin
					wr_en = 1'b1;
					wr_data = u_q;
				end
				OP_ADD: begin
					wr_en = 1'b1;
					wr_data = add_m(u_q, v_q, field_prime);
				end
				OP_SUB: begin
					wr_en = 1'b1;
					wr_data = sub_m(u_q, v_q, field_prime);
				end
				OP_MUL, OP_MOD: begin
					wr_en = (cnt_q == '0);
					wr_data = mul_next;
				end
				OP_INV: begin
					if (p_q == coord_t'(1)) begin
						wr_en = 1'b1;
						wr_data = t_q;
					end else if (t_q == field_prime - coord_t'(1)) begin
						wr_en = 1'b1;
						wr_data = '0;
					end
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	// ALU sequencing: shift-add multiply, linear inverse search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q <= OP_END;
		end else begin
			done_q <= 1'b0;
			if (cmd.go) begin
				busy_q <= 1'b1;
				op_q <= cmd.uop.op;
			end else if (busy_q && wr_en) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			dst_q <= cmd.uop.dst;
			u_q <= (cmd.uop.op == OP_MOD) ? coord_t'(1) : rd1;
			v_q <= (cmd.uop.op == OP_MOD) ? rd1 : rd2;
			r_q <= '0;
			cnt_q <= MCNT_W'(CW - 1);
			t_q <= coord_t'(1);
			p_q <= rd1;
		end else if (busy_q) begin
			r_q <= mul_next;
			v_q <= {v_q[CW-2:0], 1'b0};
			cnt_q <= cnt_q - MCNT_W'(1);
			t_q <= t_q + coord_t'(1);
			p_q <= add_m(p_q, u_q, field_prime);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bx_q <= point_x;
			by_q <= point_y;
			a_q <= curve_a;
			k_q <= scalar_k;
			x_q <= '0;
			y_q <= '0;
		end else if (cmd.shift_k) begin
			k_q <= k_q << 1;
		end else if (wr_en) begin
			case (dst_q)
				R_X:  x_q <= wr_data;
				R_Y:  y_q <= wr_data;
				R_BX: bx_q <= wr_data;
				R_BY: by_q <= wr_data;
				R_A:  a_q <= wr_data;
				R_S:  s_q <= wr_data;
				R_T0: t0_q <= wr_data;
				R_T1: t1_q <= wr_data;
				default: x_q <= x_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inf_q <= 1'b1;
		end else if (cmd.load || cmd.set_inf) begin
			inf_q <= 1'b1;
		end else if (cmd.clr_inf) begin
			inf_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			res_x_q <= inf_q ? '0 : x_q;
			res_y_q <= inf_q ? '0 : y_q;
			res_inf_q <= inf_q;
		end
	end

	assign result_x = res_x_q;
	assign result_y = res_y_q;
	assign result_is_infinity = res_inf_q;

	assign stat.done = done_q;
	assign stat.inf = inf_q;
	assign stat.y_zero = (y_q == '0);
	assign stat.x_eq = (x_q == bx_q);
	assign stat.y_eq = (y_q == by_q);
	assign stat.kbit = k_q[SW-1];
	assign stat.m_small = (field_prime < coord_t'(2));

	`ECSM_ASSERT_IMPL(a_no_go_while_busy, clk, arst_n, busy_q, !cmd.go)
	`ECSM_ASSERT_IMPL(a_mul_partial_reduced, clk, arst_n,
		busy_q && (op_q == OP_MUL || op_q == OP_MOD), r_q < field_prime)
endmodule

// File: hdl/ecsm_ctrl.sv
// Controller: bit loop over the scalar and microcode sequencing of point operations.
`include "ec_scalar_multiply_small_prime_macros.svh"
module ecsm_ctrl import ecsm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_CHECK, S_ISSUE, S_WAIT, S_DBL, S_ADD, S_NEXT, S_DONE
	} state_t;

	state_t state_q, ret_q;
	logic [PC_W-1:0] pc_q;
	logic [KCNT_W-1:0] bit_q;
	logic out_valid_q;
	uop_t uop;

	assign uop = uc_fetch(pc_q);
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.uop = uop;
		case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_ISSUE: cmd.go = (uop.op != OP_END);
			S_DBL: cmd.set_inf = stat.inf || stat.y_zero;
			S_ADD: begin
				if (stat.kbit) begin
					if (stat.inf) begin
						cmd.clr_inf = 1'b1;
					end else if (stat.x_eq && (!stat.y_eq || stat.y_zero)) begin
						cmd.set_inf = 1'b1;
					end
				end
			end
			S_NEXT: cmd.shift_k = 1'b1;
			S_DONE: cmd.capture = !out_valid_q || out_ready;
			default: cmd.go = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			pc_q <= '0;
			bit_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					bit_q <= KCNT_W'(SW - 1);
					if (stat.m_small) begin
						state_q <= S_DONE;
					end else begin
						pc_q <= PC_RED;
						ret_q <= S_DBL;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					state_q <= (uop.op == OP_END) ? ret_q : S_WAIT;
				end
				S_WAIT: begin
					if (stat.done) begin
						pc_q <= pc_q + PC_W'(1);
						state_q <= S_ISSUE;
					end
				end
				S_DBL: begin
					if (stat.inf || stat.y_zero) begin
						state_q <= S_ADD;
					end else begin
						pc_q <= PC_DBL;
						ret_q <= S_ADD;
						state_q <= S_ISSUE;
					end
				end
				S_ADD: begin
					ret_q <= S_NEXT;
					if (!stat.kbit) begin
						state_q <= S_NEXT;
					end else if (stat.inf) begin
						pc_q <= PC_LDB;
						state_q <= S_ISSUE;
					end else if (stat.x_eq) begin
						if (stat.y_eq && !stat.y_zero) begin
							pc_q <= PC_DBL;
							state_q <= S_ISSUE;
						end else begin
							state_q <= S_NEXT;
						end
					end else begin
						pc_q <= PC_ADD;
						state_q <= S_ISSUE;
					end
				end
				S_NEXT: begin
					if (bit_q == '0) begin
						state_q <= S_DONE;
					end else begin
						bit_q <= bit_q - KCNT_W'(1);
						state_q <= S_DBL;
					end
				end
				S_DONE: begin
					if (cmd.capture) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ECSM_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, in_valid && in_ready, !in_ready)
	`ECSM_ASSERT_IMPL(a_capture_slot_free, clk, arst_n, cmd.capture,
		!out_valid_q || out_ready)
endmodule

// File: bench/ecsm_checker.sv
// Scalar multiplier checker: tracks config, input and output; predicts k*P, compares.
module ecsm_checker import ecsm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic          pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic          in_valid,
	input  logic          in_ready,
	input  logic [SW-1:0] scalar_k,
	input  coord_t        point_x,
	input  coord_t        point_y,
	input  logic          out_valid,
	input  logic          out_ready,
	input  coord_t        result_x,
	input  coord_t        result_y,
	input  logic          result_is_infinity,
	output int            fail_count,
	output int            pending_count
);
	typedef struct {
		int unsigned x;
		int unsigned y;
		bit inf;
	} ecpoint_t;

	int unsigned modulus = 23;
	int unsigned coef_a = 1;
	ecpoint_t product_q[$];

	function automatic int unsigned fsub(int unsigned u, int unsigned v, int unsigned m);
		return (u + m - v) % m;
	endfunction

	function automatic int unsigned finv(int unsigned n, int unsigned m);
		int r0, r1, t0, t1, q, tmp;
		r0 = m; r1 = n; t0 = 0; t1 = 1;
		while (r1 != 0) begin
			q = r0 / r1;
			tmp = r0 - q * r1; r0 = r1; r1 = tmp;
			tmp = t0 - q * t1; t0 = t1; t1 = tmp;
		end
		if (r0 != 1) return 0;
		return ((t0 % int'(m)) + int'(m)) % int'(m);
	endfunction

	function automatic ecpoint_t from_slope(int unsigned s, ecpoint_t p, int unsigned x2,
			int unsigned m);
		ecpoint_t r;
		r.x = fsub(fsub((s * s) % m, p.x, m), x2, m);
		r.y = fsub((s * fsub(p.x, r.x, m)) % m, p.y, m);
		r.inf = 0;
		return r;
	endfunction

	function automatic ecpoint_t pdouble(ecpoint_t p, int unsigned a, int unsigned m);
		ecpoint_t r;
		int unsigned s;
		r = '{0, 0, 1};
		if (p.inf || p.y == 0) return r;
		s = (((3 * ((p.x * p.x) % m) + a) % m) * finv((2 * p.y) % m, m)) % m;
		return from_slope(s, p, p.x, m);
	endfunction

	function automatic ecpoint_t padd(ecpoint_t p, ecpoint_t q, int unsigned a,
			int unsigned m);
		ecpoint_t r;
		int unsigned s;
		r = '{0, 0, 1};
		if (p.inf) return q;
		if (q.inf) return p;
		if (p.x == q.x) begin
			if (p.y == q.y) return pdouble(p, a, m);
			return r;
		end
		s = (fsub(q.y, p.y, m) * finv(fsub(q.x, p.x, m), m)) % m;
		return from_slope(s, p, q.x, m);
	endfunction

	function automatic ecpoint_t scalar_mult(int unsigned k, int unsigned x, int unsigned y);
		ecpoint_t acc, base;
		int unsigned a;
		acc = '{0, 0, 1};
		if (modulus < 2) return acc;
		a = coef_a % modulus;
		base = '{x % modulus, y % modulus, 0};
		for (int i = SW - 1; i >= 0; i--) begin
			acc = pdouble(acc, a, modulus);
			if (k[i]) acc = padd(acc, base, a, modulus);
		end
		if (acc.inf) acc = '{0, 0, 1};
		return acc;
	endfunction

	assign pending_count = product_q.size();

	always @(posedge clk) begin
		ecpoint_t e;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_W'(4 * REG_PRIME)) modulus = pwdata[CW-1:0];
				else if (paddr == ADDR_W'(4 * REG_CURVE_A)) coef_a = pwdata[CW-1:0];
			end
			if (in_valid && in_ready)
				product_q.push_back(scalar_mult(scalar_k, point_x, point_y));
			if (out_valid && out_ready) begin
				if (product_q.size() == 0) begin
					$error("unexpected item: x=%0d y=%0d inf=%0d", result_x, result_y,
						result_is_infinity);
					fail_count <= fail_count + 1;
				end else begin
					e = product_q.pop_front();
					if (result_x !== CW'(e.x) || result_y !== CW'(e.y) ||
							result_is_infinity !== e.inf) begin
						if (result_x !== CW'(e.x))
							$error("result_x expected %0d actual %0d", e.x, result_x);
						if (result_y !== CW'(e.y))
							$error("result_y expected %0d actual %0d", e.y, result_y);
						if (result_is_infinity !== e.inf)
							$error("result_is_infinity expected %0d actual %0d", e.inf,
								result_is_infinity);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// File: bench/tb_ec_scalar_multiply_small_prime.sv
// Testbench top for the scalar multiplier: stimulus, configuration phases and verdict.
module tb_ec_scalar_multiply_small_prime;
	import ecsm_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;

	logic clk, arst_n;
	logic psel = 0, penable = 0, pwrite = 0, pready;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0, prdata;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic [SW-1:0] scalar_k = '0;
	coord_t point_x = '0, point_y = '0;
	coord_t result_x, result_y;
	logic result_is_infinity;
	int fail_count, pending_count;
	int idle_cycles = 0;
	int unsigned cur_p = 23;
	bit sender_done = 0;

	ec_scalar_multiply_small_prime u_top (.*);

	ecsm_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned gap_len();
		if ($urandom_range(9) < 3) return 0;
		if ($urandom_range(19) == 0) return $urandom_range(60, 20);
		return $urandom_range(3);
	endfunction

	task automatic cfg_write(input cfg_reg_t idx, input int unsigned value);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= ADDR_W'(4 * idx); pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == REG_PRIME) cur_p = value;
		@(posedge clk);
	endtask

	// valid drops only for a gap before an item or in drain, so back-to-back items keep it high
	task automatic send_item(input int unsigned k, input int unsigned x, input int unsigned y);
		int unsigned g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1; scalar_k <= k; point_x <= x; point_y <= y;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending_count != 0) @(posedge clk);
		repeat (6000) @(posedge clk);
	endtask

	task automatic rand_item();
		int unsigned m, k;
		m = (cur_p < 2) ? 256 : cur_p;
		case ($urandom_range(9))
			0: k = $urandom_range(255);
			1: k = $urandom_range(3);
			default: k = $urandom_range(31);
		endcase
		if ($urandom_range(9) == 0)
			send_item(k, $urandom_range(255), $urandom_range(255));
		else
			send_item(k, $urandom_range(m - 1), $urandom_range(m - 1));
	endtask

	// receiver stalls
	always @(posedge clk) begin
		if ($urandom_range(9) < 6) out_ready <= 1;
		else out_ready <= ($urandom_range(19) == 0) ? 0 : ($urandom_range(3) == 0 ? 0 : 1);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
			idle_cycles <= 0;
		else if (!(sender_done && pending_count == 0))
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// reset settings p=23, a=1; curve y^2=x^3+x+1 has (0,1), (3,10)
		send_item(0, 3, 10);
		send_item(1, 3, 10);
		send_item(2, 3, 10);
		send_item(255, 3, 10);
		send_item(28, 3, 10);
		send_item(2, 4, 0);
		send_item(1, 0, 0);
		send_item(3, 22, 22);
		send_item(7, 255, 255);
		send_item(128, 0, 1);
		send_item(170, 85, 170);
		drain();
		// pair P and -P via x equal y unequal: k=2 with y=0 also
		cfg_write(REG_CURVE_A, 0);
		send_item(5, 1, 1);
		send_item(2, 5, 0);
		drain();
		cfg_write(REG_CURVE_A, 254);
		send_item(9, 2, 7);
		drain();
		cfg_write(REG_PRIME, 0);
		send_item(5, 3, 4);
		drain();
		cfg_write(REG_PRIME, 1);
		send_item(255, 255, 255);
		drain();
		cfg_write(REG_PRIME, 15);
		send_item(13, 4, 9);
		send_item(6, 3, 5);
		drain();
		cfg_write(REG_PRIME, 3);
		cfg_write(REG_CURVE_A, 2);
		repeat (25) rand_item();
		drain();
		cfg_write(REG_PRIME, 251);
		cfg_write(REG_CURVE_A, 7);
		repeat (20) rand_item();
		drain();
		cfg_write(REG_PRIME, 255);
		cfg_write(REG_CURVE_A, 255);
		repeat (15) rand_item();
		drain();
		cfg_write(REG_PRIME, 31);
		cfg_write(REG_CURVE_A, 3);
		repeat (40) rand_item();
		drain();
		cfg_write(REG_PRIME, 2);
		cfg_write(REG_CURVE_A, 1);
		repeat (20) rand_item();
		sender_done = 1;
		drain();
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
